// ===== src/order_ref_route_table_macros.svh =====
// assertion macros for the order reference routing table
`ifndef ORDER_REF_ROUTE_TABLE_MACROS_SVH
`define ORDER_REF_ROUTE_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ORT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ORT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ort_pkg.sv =====
// shared constants for the order reference routing table
package ort_pkg;

	localparam int BUCKET_BITS = 14;
	localparam int WAYS        = 4;
	localparam int TARGETS     = 4;

	localparam int BUCKETS = 1 << BUCKET_BITS;
	localparam int WAY_IW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TGT_IW  = (TARGETS > 1) ? $clog2(TARGETS) : 1;
	localparam int KEY_W   = 64;
	localparam int INFO_W  = 36;

	localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

	// request types
	localparam logic [2:0] REQ_DIR     = 3'd0;
	localparam logic [2:0] REQ_ADD     = 3'd1;
	localparam logic [2:0] REQ_EXEC    = 3'd2;
	localparam logic [2:0] REQ_CANCEL  = 3'd3;
	localparam logic [2:0] REQ_DELETE  = 3'd4;
	localparam logic [2:0] REQ_REPLACE = 3'd5;

	// event kinds
	localparam logic [2:0] EV_ADD     = 3'd0;
	localparam logic [2:0] EV_EXEC    = 3'd1;
	localparam logic [2:0] EV_CANCEL  = 3'd2;
	localparam logic [2:0] EV_DELETE  = 3'd3;
	localparam logic [2:0] EV_REPLACE = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SYM0 = 3'd0;
	localparam logic [2:0] REG_SYM1 = 3'd1;
	localparam logic [2:0] REG_SYM2 = 3'd2;
	localparam logic [2:0] REG_SYM3 = 3'd3;
	localparam logic [2:0] REG_TIU  = 3'd4;

endpackage

// ===== src/order_ref_route_table.sv =====
// Order reference routing table: routes order events of decoded feed requests
// to up to four wanted symbols, tracking live orders in a bucketed hash table.
// Input channel: in_valid/in_stall with one request per accept; output channel:
// out_valid/out_stall with exactly one result per request, held while stalled.
// Configuration: APB port, 64-bit registers at byte address 8*i, pready high.
// After reset the table clears all 16384 bucket rows (one bucket row
// per cycle) with in_stall high; configuration writes are taken meanwhile.
// Per request: directory and unknown types go straight to the hand-off;
// add, execute, cancel and delete hash the order reference on one shared
// 32x32 multiplier, read the bucket, modify/write it back and hand off;
// a replace that finds its order then hashes and walks a second bucket.
// The bucket memories have one read and one write port with a registered read,
// and every write-back ends before the next read, so no forwarding is needed.
// A finished result moves to the output register; a new request is taken
// while it waits, and the block holds its next result until the stall drops.
module order_ref_route_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] locate_code,
	input  logic [63:0] stock_symbol,
	input  logic [47:0] time_stamp,
	input  logic [63:0] order_id,
	input  logic [63:0] new_order_ref,
	input  logic [31:0] share_count,
	input  logic [31:0] limit_price,
	input  logic        buy_sell,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        emitted,
	output logic [1:0]  target_index,
	output logic [2:0]  event_kind,
	output logic [47:0] event_time,
	output logic [63:0] event_ref,
	output logic [63:0] event_new_ref,
	output logic [31:0] event_price,
	output logic [31:0] event_shares,
	output logic        event_side,
	output logic        unroutable,
	output logic        store_failed,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	`include "order_ref_route_table_macros.svh"

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_H0   = 4'd1;
	localparam logic [3:0] ST_H1   = 4'd2;
	localparam logic [3:0] ST_H2   = 4'd3;
	localparam logic [3:0] ST_H3   = 4'd4;
	localparam logic [3:0] ST_RD   = 4'd5;
	localparam logic [3:0] ST_MOD  = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;
	localparam logic [3:0] ST_CLR  = 4'd8;

	localparam int KW = ort_pkg::KEY_W;
	localparam int IW = ort_pkg::INFO_W;

	logic [3:0]  state_q;
	logic [ort_pkg::BUCKET_BITS-1:0] clr_q;

	// configuration
	logic [63:0] sym_q [4];
	logic [2:0]  tiu_q;
	logic        cfg_wr;

	// target locates
	logic        loc_valid_q [ort_pkg::TARGETS];
	logic [15:0] loc_code_q  [ort_pkg::TARGETS];

	// request working registers
	logic [2:0]  type_q;
	logic [47:0] ts_q;
	logic [63:0] ref_q;
	logic [63:0] nref_q;
	logic [31:0] shares_q;
	logic [31:0] price_q;
	logic        side_q;
	logic [63:0] key_q;
	logic [2:0]  slot_q;
	logic        phase_q;
	logic        unr_q;
	logic        fail_q;

	// hash
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_q;
	logic [63:0] hash_q;
	logic [ort_pkg::BUCKET_BITS-1:0] bucket;

	// bucket memories
	logic [ort_pkg::WAYS*KW-1:0] key_mem  [ort_pkg::BUCKETS];
	logic [ort_pkg::WAYS*IW-1:0] info_mem [ort_pkg::BUCKETS];
	logic [ort_pkg::WAYS*KW-1:0] key_rd_q;
	logic [ort_pkg::WAYS*IW-1:0] info_rd_q;
	logic [ort_pkg::WAYS*KW-1:0] key_wdata;
	logic [ort_pkg::WAYS*IW-1:0] info_wdata;
	logic [ort_pkg::BUCKET_BITS-1:0] wr_addr;
	logic        key_we;
	logic        info_we;

	// modify logic
	logic        hit;
	logic [ort_pkg::WAY_IW-1:0] hit_w;
	logic        free;
	logic [ort_pkg::WAY_IW-1:0] free_w;
	logic [IW-1:0] hit_info;
	logic        ins_mode;
	logic        ins_ok;
	logic [ort_pkg::WAY_IW-1:0] ins_w;
	logic [31:0] rest;
	logic [31:0] take;
	logic [31:0] nrest;
	logic [IW-1:0] upd_info;

	// accept-time logic
	logic        accept;
	logic [2:0]  n_act;
	logic        dir_hit;
	logic [ort_pkg::TGT_IW-1:0] dir_idx;
	logic [2:0]  add_slot;

	// result composition
	logic        res_emit;
	logic [2:0]  res_kind;
	logic        out_load;

	logic        out_valid_q;
	logic        emitted_q;
	logic [1:0]  target_index_q;
	logic [2:0]  event_kind_q;
	logic [47:0] event_time_q;
	logic [63:0] event_ref_q;
	logic [63:0] event_new_ref_q;
	logic [31:0] event_price_q;
	logic [31:0] event_shares_q;
	logic        event_side_q;
	logic        unroutable_q;
	logic        store_failed_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) sym_q[i] <= '0;
			tiu_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				ort_pkg::REG_SYM0: sym_q[0] <= pwdata;
				ort_pkg::REG_SYM1: sym_q[1] <= pwdata;
				ort_pkg::REG_SYM2: sym_q[2] <= pwdata;
				ort_pkg::REG_SYM3: sym_q[3] <= pwdata;
				ort_pkg::REG_TIU:  tiu_q    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			ort_pkg::REG_SYM0: prdata = sym_q[0];
			ort_pkg::REG_SYM1: prdata = sym_q[1];
			ort_pkg::REG_SYM2: prdata = sym_q[2];
			ort_pkg::REG_SYM3: prdata = sym_q[3];
			ort_pkg::REG_TIU:  prdata = {61'd0, tiu_q};
			default:           prdata = '0;
		endcase
	end

	// directory match and add slot lookup
	always_comb begin
		n_act = (tiu_q > 3'(ort_pkg::TARGETS)) ? 3'(ort_pkg::TARGETS) : tiu_q;
		dir_hit = 1'b0;
		dir_idx = '0;
		add_slot = '0;
		for (int i = 0; i < ort_pkg::TARGETS; i++) begin
			if (3'(i) < n_act && sym_q[i] == stock_symbol) begin
				dir_hit = 1'b1;
				dir_idx = ort_pkg::TGT_IW'(i);
			end
			if (loc_valid_q[i] && loc_code_q[i] == locate_code)
				add_slot = 3'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ort_pkg::TARGETS; i++) loc_valid_q[i] <= 1'b0;
		end else if (accept && req_type == ort_pkg::REQ_DIR && dir_hit) begin
			// a locate belongs to one target at a time
			for (int i = 0; i < ort_pkg::TARGETS; i++)
				if (loc_valid_q[i] && loc_code_q[i] == locate_code)
					loc_valid_q[i] <= 1'b0;
			loc_valid_q[dir_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == ort_pkg::REQ_DIR && dir_hit)
			loc_code_q[dir_idx] <= locate_code;
	end

	// hash: low 64 bits of key times constant, built from three 32x32 products
	always_comb begin
		case (state_q)
			ST_H1: begin
				mul_a = key_q[63:32];
				mul_b = ort_pkg::HASH_MUL[31:0];
			end
			ST_H2: begin
				mul_a = key_q[31:0];
				mul_b = ort_pkg::HASH_MUL[63:32];
			end
			default: begin
				mul_a = key_q[31:0];
				mul_b = ort_pkg::HASH_MUL[31:0];
			end
		endcase
	end

	assign bucket = hash_q[63 -: ort_pkg::BUCKET_BITS];

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			ST_H1:   hash_q <= prod_q;
			ST_H2:   hash_q <= hash_q + {prod_q[31:0], 32'd0};
			ST_H3:   hash_q <= hash_q + {prod_q[31:0], 32'd0};
			default: ;
		endcase
	end

	// bucket row search
	always_comb begin
		hit    = 1'b0;
		hit_w  = '0;
		free   = 1'b0;
		free_w = '0;
		for (int w = ort_pkg::WAYS - 1; w >= 0; w--) begin
			if (info_rd_q[w*IW + IW - 1] && key_rd_q[w*KW +: KW] == key_q) begin
				hit   = 1'b1;
				hit_w = ort_pkg::WAY_IW'(w);
			end
			if (!info_rd_q[w*IW + IW - 1]) begin
				free   = 1'b1;
				free_w = ort_pkg::WAY_IW'(w);
			end
		end
		hit_info = info_rd_q[hit_w*IW +: IW];
		ins_mode = (type_q == ort_pkg::REQ_ADD) || phase_q;
		ins_ok   = hit || free;
		ins_w    = hit ? hit_w : free_w;
		rest     = hit_info[31:0];
		take     = (shares_q < rest) ? shares_q : rest;
		nrest    = rest - take;
		if (type_q == ort_pkg::REQ_EXEC || type_q == ort_pkg::REQ_CANCEL)
			upd_info = (nrest == 32'd0) ? '0 : {hit_info[IW-1:32], nrest};
		else
			upd_info = '0;

		key_wdata  = key_rd_q;
		info_wdata = info_rd_q;
		key_we     = 1'b0;
		info_we    = 1'b0;
		wr_addr    = bucket;
		if (state_q == ST_CLR) begin
			info_we    = 1'b1;
			info_wdata = '0;
			wr_addr    = clr_q;
		end else if (state_q == ST_MOD) begin
			if (ins_mode) begin
				key_we  = ins_ok;
				info_we = ins_ok;
				key_wdata[ins_w*KW +: KW]  = key_q;
				info_wdata[ins_w*IW +: IW] = {1'b1, slot_q, shares_q};
			end else if (hit) begin
				info_we = 1'b1;
				info_wdata[hit_w*IW +: IW] = upd_info;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (info_we) info_mem[wr_addr] <= info_wdata;
		if (key_we)  key_mem[wr_addr]  <= key_wdata;
		key_rd_q  <= key_mem[bucket];
		info_rd_q <= info_mem[bucket];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (req_type >= ort_pkg::REQ_ADD && req_type <= ort_pkg::REQ_REPLACE)
							state_q <= ST_H0;
						else
							state_q <= ST_FIN;
					end
				end
				ST_H0: state_q <= ST_H1;
				ST_H1: state_q <= ST_H2;
				ST_H2: state_q <= ST_H3;
				ST_H3: state_q <= ST_RD;
				ST_RD: state_q <= ST_MOD;
				ST_MOD: begin
					// a found replace goes on to insert the new reference
					if (!ins_mode && hit && type_q == ort_pkg::REQ_REPLACE)
						state_q <= ST_H0;
					else
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q   <= req_type;
			ts_q     <= time_stamp;
			ref_q    <= order_id;
			nref_q   <= new_order_ref;
			shares_q <= share_count;
			price_q  <= limit_price;
			side_q   <= buy_sell;
			key_q    <= order_id;
			phase_q  <= 1'b0;
			unr_q    <= 1'b0;
			fail_q   <= 1'b0;
			slot_q   <= (req_type == ort_pkg::REQ_ADD) ? add_slot : 3'd0;
		end else if (state_q == ST_MOD) begin
			if (ins_mode) begin
				fail_q <= !ins_ok;
			end else if (!hit) begin
				unr_q <= 1'b1;
			end else begin
				slot_q <= hit_info[34:32];
				if (type_q == ort_pkg::REQ_REPLACE) begin
					key_q   <= nref_q;
					phase_q <= 1'b1;
				end
			end
		end
	end

	// result
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign res_emit = !unr_q && slot_q != 3'd0;

	always_comb begin
		case (type_q)
			ort_pkg::REQ_EXEC:    res_kind = ort_pkg::EV_EXEC;
			ort_pkg::REQ_CANCEL:  res_kind = ort_pkg::EV_CANCEL;
			ort_pkg::REQ_DELETE:  res_kind = ort_pkg::EV_DELETE;
			ort_pkg::REQ_REPLACE: res_kind = ort_pkg::EV_REPLACE;
			default:              res_kind = ort_pkg::EV_ADD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			emitted_q       <= res_emit;
			target_index_q  <= res_emit ? 2'(slot_q - 3'd1) : 2'd0;
			event_kind_q    <= res_emit ? res_kind : 3'd0;
			event_time_q    <= res_emit ? ts_q : 48'd0;
			event_ref_q     <= res_emit ? ref_q : 64'd0;
			event_new_ref_q <= (res_emit && type_q == ort_pkg::REQ_REPLACE) ? nref_q : 64'd0;
			event_price_q   <= (res_emit && (type_q == ort_pkg::REQ_ADD
				|| type_q == ort_pkg::REQ_REPLACE)) ? price_q : 32'd0;
			event_shares_q  <= (res_emit && type_q != ort_pkg::REQ_DELETE) ? shares_q : 32'd0;
			event_side_q    <= (res_emit && type_q == ort_pkg::REQ_ADD) ? side_q : 1'b0;
			unroutable_q    <= unr_q;
			store_failed_q  <= fail_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign emitted       = emitted_q;
	assign target_index  = target_index_q;
	assign event_kind    = event_kind_q;
	assign event_time    = event_time_q;
	assign event_ref     = event_ref_q;
	assign event_new_ref = event_new_ref_q;
	assign event_price   = event_price_q;
	assign event_shares  = event_shares_q;
	assign event_side    = event_side_q;
	assign unroutable    = unroutable_q;
	assign store_failed  = store_failed_q;

	`ORT_ASSERT_NOW(a_mem_write_state, info_we || key_we,
		state_q == ST_MOD || state_q == ST_CLR, "table written outside modify or clear")
	`ORT_ASSERT_NOW(a_emit_not_unroutable, out_valid_q && emitted_q,
		!unroutable_q, "event emitted for an unroutable request")
	`ORT_ASSERT_NOW(a_quiet_fields, out_valid_q && !emitted_q,
		event_ref_q == 64'd0 && event_shares_q == 32'd0 && event_kind_q == 3'd0,
		"event fields set without an event")
	`ORT_ASSERT_NEXT(a_clear_exit, state_q == ST_CLR,
		state_q == ST_CLR || state_q == ST_IDLE, "clearing pass left to a working state")

endmodule
